[rtl/bdq_pkg.sv]
`timescale 1ns / 1ps

package bdq_pkg;

  localparam int DEPTH_DEF = 64;

  localparam int OP_W    = 3;
  localparam int VALUE_W = 32;
  localparam int POS_W   = 7;
  localparam int STAT_W  = 2;

  // operation codes; 5 to 7 are no-ops
  localparam logic [OP_W-1:0] OP_PUSH_FRONT = 3'd0;
  localparam logic [OP_W-1:0] OP_PUSH_BACK  = 3'd1;
  localparam logic [OP_W-1:0] OP_POP_FRONT  = 3'd2;
  localparam logic [OP_W-1:0] OP_POP_BACK   = 3'd3;
  localparam logic [OP_W-1:0] OP_SEARCH     = 3'd4;

  localparam logic [STAT_W-1:0] ST_OK       = 2'd0;
  localparam logic [STAT_W-1:0] ST_EMPTY    = 2'd1;
  localparam logic [STAT_W-1:0] ST_FULL     = 2'd2;
  localparam logic [STAT_W-1:0] ST_NOTFOUND = 2'd3;

  typedef struct packed {
    logic [OP_W-1:0]           operation;
    logic signed [VALUE_W-1:0] value;
  } in_word_t;

  typedef struct packed {
    logic [STAT_W-1:0]         status;
    logic [POS_W-1:0]          found_position;
    logic [POS_W-1:0]          entry_count;
    logic signed [VALUE_W-1:0] entry_sum;
  } out_word_t;

endpackage

[rtl/bounded_deque_with_search.sv]
`timescale 1ns / 1ps

// Bounded double-ended queue of signed 32-bit words, held as a ring in one RAM.
// Input channel in_valid/in_ready/in_data carries an operation and a value:
// push front, push back, pop front, pop back or search. Each accepted word
// gives exactly one result word on out_valid/out_ready/out_data: status, the
// 1-based position of the first match from the front (search only), and the
// entry count and wrapping sum after the operation.
// Work per word, from acceptance to the result register:
//   push            RAM write in the accept cycle
//   pop             one RAM read, registered
//   search          k entries compared, k the number compared (1..DEPTH);
//                   the scan reads one RAM entry per cycle
//   empty pop/search, full push, unused codes: finished in the accept cycle
// Each result is registered at the end of its last work cycle. A new word is taken in
// the cycle after the previous result is written to the output register.
// If the receiver stalls with a result still in the output register, the next
// finished result waits in a hold register and input is held off until the
// output register frees up.
// Reset (rst_n low, synchronous) empties the queue, clears the sum and the
// output valid. The RAM itself is not cleared; no empty entry is ever read.
module bounded_deque_with_search #(
  parameter int DEPTH = bdq_pkg::DEPTH_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  bdq_pkg::in_word_t   in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output bdq_pkg::out_word_t  out_data
);

  localparam int PW = $clog2(DEPTH);      // ring index width
  localparam int CW = $clog2(DEPTH + 1);  // count width, holds DEPTH itself
  localparam logic [PW:0]   DEPTH_W  = (PW + 1)'(DEPTH);
  localparam logic [PW-1:0] LAST_IDX = PW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  typedef enum logic [1:0] {S_IDLE, S_POP, S_SRCH, S_HOLD} state_t;

  // front + offset, wrapped once (both below DEPTH so one subtract suffices)
  function automatic logic [PW-1:0] ring_add(logic [PW-1:0] base, logic [CW-1:0] off);
    logic [PW:0] s;
    s = {1'b0, base} + (PW + 1)'(off);
    if (s >= DEPTH_W) begin
      s = s - DEPTH_W;
    end
    return s[PW-1:0];
  endfunction

  function automatic logic [PW-1:0] ring_inc(logic [PW-1:0] idx);
    return (idx == LAST_IDX) ? '0 : idx + PW'(1);
  endfunction

  state_t state_r, state_nxt;
  logic [PW-1:0] front_r, front_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic signed [bdq_pkg::VALUE_W-1:0] sum_r, sum_nxt;
  logic [bdq_pkg::OP_W-1:0] op_r, op_nxt;
  logic signed [bdq_pkg::VALUE_W-1:0] val_r, val_nxt;
  logic [PW-1:0] scan_r, scan_nxt;       // offset of the entry being compared
  logic [PW-1:0] addr_r, addr_nxt;       // ring address of that entry
  bdq_pkg::out_word_t res_r, res_nxt;    // hold slot
  bdq_pkg::out_word_t out_r, out_nxt;
  logic out_valid_r, out_valid_nxt;

  // RAM port
  logic                         ram_we;
  logic [PW-1:0]                ram_waddr;
  logic [bdq_pkg::VALUE_W-1:0]  ram_wdata;
  logic [PW-1:0]                ram_raddr;
  logic [bdq_pkg::VALUE_W-1:0]  ram_rdata;

  // completion of the current word
  logic                 done;
  logic [bdq_pkg::STAT_W-1:0] done_status;
  logic [bdq_pkg::POS_W-1:0]  done_pos;
  logic                 slot_free;
  logic [CW-1:0]        scan_p1;
  bdq_pkg::out_word_t   done_word;

  bdq_ram #(
    .WIDTH (bdq_pkg::VALUE_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (ram_waddr),
    .wr_data (ram_wdata),
    .rd_addr (ram_raddr),
    .rd_data (ram_rdata)
  );

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;
  assign slot_free = !out_valid_r || out_ready;
  assign scan_p1   = CW'(scan_r) + CW'(1);

  always_comb begin
    state_nxt   = state_r;
    front_nxt   = front_r;
    count_nxt   = count_r;
    sum_nxt     = sum_r;
    op_nxt      = op_r;
    val_nxt     = val_r;
    scan_nxt    = scan_r;
    addr_nxt    = addr_r;
    res_nxt     = res_r;
    out_nxt     = out_r;
    out_valid_nxt = out_valid_r && !out_ready;
    ram_we      = 1'b0;
    ram_waddr   = front_r;
    ram_wdata   = in_data.value;
    ram_raddr   = addr_r;
    done        = 1'b0;
    done_status = bdq_pkg::ST_OK;
    done_pos    = '0;

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          op_nxt = in_data.operation;
          val_nxt = in_data.value;
          unique case (in_data.operation)
            bdq_pkg::OP_PUSH_FRONT, bdq_pkg::OP_PUSH_BACK: begin
              done = 1'b1;
              if (count_r >= FULL_CNT) begin
                done_status = bdq_pkg::ST_FULL;
              end else begin
                ram_we    = 1'b1;
                count_nxt = count_r + CW'(1);
                sum_nxt   = sum_r + in_data.value;
                if (in_data.operation == bdq_pkg::OP_PUSH_FRONT) begin
                  front_nxt = (front_r == '0) ? LAST_IDX : front_r - PW'(1);
                  ram_waddr = front_nxt;
                end else begin
                  ram_waddr = ring_add(front_r, count_r);
                end
              end
            end
            bdq_pkg::OP_POP_FRONT, bdq_pkg::OP_POP_BACK: begin
              if (count_r == '0) begin
                done        = 1'b1;
                done_status = bdq_pkg::ST_EMPTY;
              end else begin
                ram_raddr = (in_data.operation == bdq_pkg::OP_POP_FRONT) ? front_r
                          : ring_add(front_r, count_r - CW'(1));
                state_nxt = S_POP;
              end
            end
            bdq_pkg::OP_SEARCH: begin
              if (count_r == '0) begin
                done        = 1'b1;
                done_status = bdq_pkg::ST_NOTFOUND;
              end else begin
                ram_raddr = front_r;
                addr_nxt  = front_r;
                scan_nxt  = '0;
                state_nxt = S_SRCH;
              end
            end
            default: begin
              done = 1'b1;
            end
          endcase
        end
      end
      S_POP: begin
        done      = 1'b1;
        sum_nxt   = sum_r - $signed(ram_rdata);
        count_nxt = count_r - CW'(1);
        if (op_r == bdq_pkg::OP_POP_FRONT) begin
          front_nxt = ring_inc(front_r);
        end
      end
      S_SRCH: begin
        // ram_rdata is the entry at offset scan_r
        if (ram_rdata == $unsigned(val_r)) begin
          done     = 1'b1;
          done_pos = bdq_pkg::POS_W'(scan_p1);
        end else if (scan_p1 == count_r) begin
          done        = 1'b1;
          done_status = bdq_pkg::ST_NOTFOUND;
        end else begin
          scan_nxt  = scan_r + PW'(1);
          addr_nxt  = ring_inc(addr_r);
          ram_raddr = addr_nxt;
        end
      end
      S_HOLD: begin
        if (slot_free) begin
          out_nxt       = res_r;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    done_word.status         = done_status;
    done_word.found_position = done_pos;
    done_word.entry_count    = bdq_pkg::POS_W'(count_nxt);
    done_word.entry_sum      = sum_nxt;

    if (done) begin
      if (slot_free) begin
        out_nxt       = done_word;
        out_valid_nxt = 1'b1;
        state_nxt     = S_IDLE;
      end else begin
        res_nxt   = done_word;
        state_nxt = S_HOLD;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      front_r     <= '0;
      count_r     <= '0;
      sum_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      front_r     <= front_nxt;
      count_r     <= count_nxt;
      sum_r       <= sum_nxt;
      out_valid_r <= out_valid_nxt;
    end
    op_r   <= op_nxt;
    val_r  <= val_nxt;
    scan_r <= scan_nxt;
    addr_r <= addr_nxt;
    res_r  <= res_nxt;
    out_r  <= out_nxt;
  end

`ifndef NO_ASSERTIONS
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= FULL_CNT)
    else $error("entry count above depth");

  a_scan_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SRCH) |-> (CW'(scan_r) < count_r))
    else $error("search scan past last entry");

  a_push_grows: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && count_r < FULL_CNT &&
     (in_data.operation == bdq_pkg::OP_PUSH_FRONT ||
      in_data.operation == bdq_pkg::OP_PUSH_BACK))
    |=> (count_r == $past(count_r) + CW'(1)))
    else $error("push did not grow the queue");

  a_search_keeps_state: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SRCH) |=> (count_r == $past(count_r) && front_r == $past(front_r)))
    else $error("search changed the queue");

  a_hold_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_HOLD && !slot_free) |=> (state_r == S_HOLD && out_valid_r))
    else $error("held result lost");
`endif

endmodule

[rtl/bdq_ram.sv]
`timescale 1ns / 1ps

module bdq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule
